FILE: rtl/core/keyed_fifo_unique_keys_macros.svh
// Assertion helpers shared by the keyed FIFO sources.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef KEYED_FIFO_UNIQUE_KEYS_MACROS_SVH
`define KEYED_FIFO_UNIQUE_KEYS_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define KFUK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define KFUK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/kfuk_pkg.sv
package kfuk_pkg;

  // Queue geometry; the depth is a power of two so slot indexes wrap freely
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int CMD_W  = 2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] key_in;
    logic signed [DATA_W-1:0] value_in;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] key_out;
    logic signed [DATA_W-1:0] value_out;
    logic [CNT_W-1:0]         count_out;
  } rsp_t;

  // Store access from the sequencer: one write port, one read port
  typedef struct packed {
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_key;
    logic signed [DATA_W-1:0] wr_value;
    logic [IDX_W-1:0]         rd_addr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_LOAD,
    ST_RESP
  } state_t;

endpackage

FILE: rtl/core/kfuk_store.sv
module kfuk_store (
  input  logic                              clk,
  input  kfuk_pkg::mem_req_t                mem,
  output logic signed [kfuk_pkg::DATA_W-1:0] rd_key,
  output logic signed [kfuk_pkg::DATA_W-1:0] rd_value
);

  logic signed [kfuk_pkg::DATA_W-1:0] key_mem   [kfuk_pkg::DEPTH];
  logic signed [kfuk_pkg::DATA_W-1:0] value_mem [kfuk_pkg::DEPTH];

  // Write the pair at the tail slot
  always_ff @(posedge clk) begin
    if (mem.wr_en) begin
      key_mem[mem.wr_addr]   <= mem.wr_key;
      value_mem[mem.wr_addr] <= mem.wr_value;
    end
  end

  // Read one slot per cycle, data registered
  always_ff @(posedge clk) begin
    rd_key   <= key_mem[mem.rd_addr];
    rd_value <= value_mem[mem.rd_addr];
  end

endmodule

FILE: rtl/core/kfuk_ctrl.sv
`include "keyed_fifo_unique_keys_macros.svh"

module kfuk_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  kfuk_pkg::req_t                     req,
  output logic                               res_valid,
  input  logic                               res_ready,
  output kfuk_pkg::rsp_t                     res,
  output kfuk_pkg::mem_req_t                 mem,
  input  logic signed [kfuk_pkg::DATA_W-1:0] rd_key,
  input  logic signed [kfuk_pkg::DATA_W-1:0] rd_value
);

  kfuk_pkg::state_t state;
  kfuk_pkg::state_t state_next;

  // Control registers
  logic [kfuk_pkg::IDX_W-1:0] head;
  logic [kfuk_pkg::CNT_W-1:0] count;
  logic [kfuk_pkg::CNT_W-1:0] scan_idx;
  logic                       cmp_pend;

  // Item and result registers
  logic [kfuk_pkg::CMD_W-1:0]         cmd_reg;
  logic signed [kfuk_pkg::DATA_W-1:0] key_reg;
  logic signed [kfuk_pkg::DATA_W-1:0] value_reg;
  logic [kfuk_pkg::POS_W-1:0]         pos_reg;
  logic                               res_ok;
  logic signed [kfuk_pkg::DATA_W-1:0] res_key;
  logic signed [kfuk_pkg::DATA_W-1:0] res_value;

  logic                       req_fire;
  logic                       start_ok;
  logic                       match;
  logic                       scan_done;
  logic                       pop_load;
  logic [kfuk_pkg::POS_W-1:0] pos_off;

  assign req_fire  = req_valid && req_ready;
  assign match     = cmp_pend && (rd_key == key_reg);
  assign scan_done = (scan_idx == count);
  assign pop_load  = (state == kfuk_pkg::ST_LOAD) && (cmd_reg == kfuk_pkg::CMD_POP);
  assign pos_off   = pos_reg - 1'b1;

  // Decide whether the incoming item needs the store at all
  always_comb begin
    case (req.cmd)
      kfuk_pkg::CMD_PUSH: start_ok = (count < kfuk_pkg::DEPTH_CNT);
      kfuk_pkg::CMD_POP:  start_ok = (count != '0);
      kfuk_pkg::CMD_READ: start_ok = (req.position != '0) &&
                                     (req.position <= count);
      default:            start_ok = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      kfuk_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (!start_ok) begin
            state_next = kfuk_pkg::ST_RESP;
          end else if (req.cmd == kfuk_pkg::CMD_PUSH) begin
            state_next = kfuk_pkg::ST_SCAN;
          end else begin
            state_next = kfuk_pkg::ST_FETCH;
          end
        end
      end
      kfuk_pkg::ST_SCAN: begin
        if (match || scan_done) begin
          state_next = kfuk_pkg::ST_RESP;
        end
      end
      kfuk_pkg::ST_FETCH: state_next = kfuk_pkg::ST_LOAD;
      kfuk_pkg::ST_LOAD:  state_next = kfuk_pkg::ST_RESP;
      kfuk_pkg::ST_RESP: begin
        if (res_ready) begin
          state_next = kfuk_pkg::ST_IDLE;
        end
      end
      default: state_next = kfuk_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshakes and store access
  always_comb begin
    req_ready    = (state == kfuk_pkg::ST_IDLE);
    res_valid    = (state == kfuk_pkg::ST_RESP);
    mem.wr_en    = 1'b0;
    mem.wr_addr  = head + count[kfuk_pkg::IDX_W-1:0];
    mem.wr_key   = key_reg;
    mem.wr_value = value_reg;
    mem.rd_addr  = head + scan_idx[kfuk_pkg::IDX_W-1:0];
    case (state)
      kfuk_pkg::ST_SCAN: begin
        mem.wr_en = !match && scan_done;
      end
      kfuk_pkg::ST_FETCH: begin
        if (cmd_reg == kfuk_pkg::CMD_READ) begin
          mem.rd_addr = head + pos_off[kfuk_pkg::IDX_W-1:0];
        end else begin
          mem.rd_addr = head;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.ok        = res_ok;
  assign res.key_out   = res_key;
  assign res.value_out = res_value;
  assign res.count_out = count;

  // Advance the sequencer, queue pointers and scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kfuk_pkg::ST_IDLE;
      head     <= '0;
      count    <= '0;
      scan_idx <= '0;
      cmp_pend <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        kfuk_pkg::ST_IDLE: begin
          scan_idx <= '0;
          cmp_pend <= 1'b0;
        end
        kfuk_pkg::ST_SCAN: begin
          if (!match && !scan_done) begin
            scan_idx <= scan_idx + 1'b1;
            cmp_pend <= 1'b1;
          end else if (!match) begin
            count <= count + 1'b1;
          end
        end
        kfuk_pkg::ST_LOAD: begin
          if (cmd_reg == kfuk_pkg::CMD_POP) begin
            head  <= head + 1'b1;
            count <= count - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the item and build the result
  always_ff @(posedge clk) begin
    case (state)
      kfuk_pkg::ST_IDLE: begin
        if (req_fire) begin
          cmd_reg   <= req.cmd;
          key_reg   <= req.key_in;
          value_reg <= req.value_in;
          pos_reg   <= req.position;
          res_ok    <= 1'b0;
          res_key   <= '0;
          res_value <= '0;
        end
      end
      kfuk_pkg::ST_SCAN: begin
        if (!match && scan_done) begin
          res_ok <= 1'b1;
        end
      end
      kfuk_pkg::ST_LOAD: begin
        res_ok    <= 1'b1;
        res_key   <= rd_key;
        res_value <= rd_value;
      end
      default: begin
      end
    endcase
  end

  `KFUK_ASSERT_IMP(a_count_max, 1'b1, count <= kfuk_pkg::DEPTH_CNT, "count beyond depth")
  `KFUK_ASSERT_IMP(a_wr_room, mem.wr_en, count < kfuk_pkg::DEPTH_CNT, "write into full queue")
  `KFUK_ASSERT_NXT(a_wr_count, mem.wr_en, count == $past(count) + 1'b1, "push did not count")
  `KFUK_ASSERT_NXT(a_pop_head, pop_load, head == $past(head) + 1'b1, "pop did not advance head")

endmodule

FILE: rtl/core/keyed_fifo_unique_keys.sv
// Keyed FIFO with unique keys: a queue of up to 16 key/value pairs.
// Request channel req_valid/req_ready/req carries cmd (push, pop, nop, read at
// a one-based position), key_in, value_in and position. Response channel
// rsp_valid/rsp_ready/rsp returns ok, key_out, value_out and count_out,
// exactly one response item per request item, in order.
// A push scans the stored keys one per cycle through a single read port
// and one 32-bit comparator, then writes the tail slot if no key matched.
// A pop or in-range read fetches one slot from the store; a rejected item
// goes straight to the response state. Each result is then registered in
// the output register before it appears on rsp.
// req_ready is high only while the sequencer is idle; it may take the next
// item while the previous response still sits in the output register.
// A stalled receiver holds the response, and the sequencer then waits with
// its finished result until the output register frees up.
// Reset empties the queue (count and head to zero); store contents are not
// cleared, as data read from unwritten slots is never used.
module keyed_fifo_unique_keys (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  kfuk_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output kfuk_pkg::rsp_t rsp
);

  kfuk_pkg::mem_req_t                 mem;
  kfuk_pkg::rsp_t                     res;
  logic                               res_valid;
  logic                               res_ready;
  logic signed [kfuk_pkg::DATA_W-1:0] rd_key;
  logic signed [kfuk_pkg::DATA_W-1:0] rd_value;

  kfuk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem       (mem),
    .rd_key    (rd_key),
    .rd_value  (rd_value)
  );

  kfuk_store u_store (
    .clk      (clk),
    .mem      (mem),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  // Output register: take a result when empty or being drained
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule
